// ----- design/wbps_pkg.sv -----
`default_nettype none

package wbps_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = PTR_W + 1;
  localparam int COORD_W    = 32;
  localparam int OVL_W      = 4;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int NUM_W      = COORD_W + 8;
  localparam int DIV_STEPS  = NUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(32);
  localparam logic [OVL_W-1:0] OVL_RESET = OVL_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_OVERLAP_HALF  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_EMIT  = 1'b1
  } op_kind_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_MUL,
    B_PREP,
    B_DIV,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic                      in_last;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      run_last;
    logic                      path_end;
  } out_t;

  // One command from the front to the back: store a point, or sample a curve.
  typedef struct packed {
    op_kind_e                  kind;
    logic [PTR_W-1:0]          addr;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [CNT_W-1:0]          n;
    logic [CNT_W-1:0]          first;
    logic [CNT_W-1:0]          stop;
    logic [PTR_W-1:0]          base;
    logic                      run_last;
    logic                      path_end;
  } op_t;

endpackage

`default_nettype wire

// ----- design/wbps_fifo.sv -----
`default_nettype none

module wbps_fifo import wbps_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  data_i,
  output logic      ready_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output op_t       data_o
);

  op_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_PTR_W:0]   cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign ready_o = (cnt_q != (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/wbps_front.sv -----
`default_nettype none

module wbps_front import wbps_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire in_t                   in_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output op_t                        op_o,
  output logic                       op_valid_o,
  input  wire logic                  op_ready_i
);

  logic [CNT_W-1:0] win_q, win_d;
  logic [OVL_W-1:0] ovl_q, ovl_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [PTR_W-1:0] base_q, base_d;
  logic             past_q, past_d;
  op_t              pend_q [3];
  op_t              pend_d [3];
  logic [1:0]       pend_cnt_q, pend_cnt_d;
  logic [1:0]       pend_idx_q, pend_idx_d;

  logic [CNT_W-1:0] eff_len, half_max, eff_half, ovl_c, fill_cur, n_pts;
  logic [PTR_W-1:0] base_next;
  logic             accept, have_e1, have_e2;
  op_t              st_op, e1, e2;

  function automatic op_t make_emit(logic [CNT_W-1:0] n, logic [CNT_W-1:0] first,
                                    logic [CNT_W-1:0] stop, logic [PTR_W-1:0] base);
    op_t o;
    o          = '0;
    o.kind     = OP_EMIT;
    o.n        = n;
    o.first    = first;
    o.stop     = stop;
    o.base     = base;
    return o;
  endfunction

  assign full       = (pend_cnt_q != 2'd0);
  assign accept     = push & ~full;
  assign op_valid_o = (pend_cnt_q != 2'd0);
  assign op_o       = pend_q[pend_idx_q];

  always_comb begin
    if (win_q < CNT_W'(2)) begin
      eff_len = CNT_W'(2);
    end else if (win_q > CNT_W'(MAX_WINDOW)) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = win_q;
    end
    half_max  = (eff_len - 1'b1) >> 1;
    eff_half  = (CNT_W'(ovl_q) > half_max) ? half_max : CNT_W'(ovl_q);
    ovl_c     = eff_half << 1;
    fill_cur  = (fill_q >= eff_len) ? '0 : fill_q;
    n_pts     = fill_cur + 1'b1;
    base_next = base_q + PTR_W'(eff_len - ovl_c);
  end

  always_comb begin
    st_op      = '0;
    st_op.kind = OP_STORE;
    st_op.addr = base_q + fill_cur[PTR_W-1:0];
    st_op.px   = in_i.in_x;
    st_op.py   = in_i.in_y;
  end

  always_comb begin
    win_d      = win_q;
    ovl_d      = ovl_q;
    fill_d     = fill_q;
    base_d     = base_q;
    past_d     = past_q;
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    pend_idx_d = pend_idx_q;
    have_e1    = 1'b0;
    have_e2    = 1'b0;
    e1         = make_emit(n_pts, '0, n_pts, base_q);
    e2         = make_emit(ovl_c, eff_half, ovl_c, base_next);

    // Drain pending commands into the queue, one a cycle while it has room.
    if (op_valid_o && op_ready_i) begin
      if (pend_idx_q + 1'b1 == pend_cnt_q) begin
        pend_cnt_d = 2'd0;
        pend_idx_d = 2'd0;
      end else begin
        pend_idx_d = pend_idx_q + 1'b1;
      end
    end

    if (accept) begin
      fill_d = n_pts;
      if (!past_q) begin
        if (in_i.in_last) begin
          have_e1 = (n_pts >= CNT_W'(2));
          fill_d  = '0;
        end else if (n_pts == eff_len) begin
          have_e1 = 1'b1;
          e1      = make_emit(eff_len, '0, eff_len - eff_half, base_q);
          base_d  = base_next;
          fill_d  = ovl_c;
          past_d  = 1'b1;
        end
      end else if (n_pts == eff_len) begin
        have_e1 = 1'b1;
        e1      = make_emit(eff_len, eff_half, eff_len - eff_half, base_q);
        base_d  = base_next;
        fill_d  = ovl_c;
        if (in_i.in_last) begin
          have_e2 = (ovl_c >= CNT_W'(2));
          fill_d  = '0;
          past_d  = 1'b0;
        end
      end else if (in_i.in_last) begin
        have_e1 = (n_pts >= CNT_W'(2));
        e1      = make_emit(n_pts, eff_half, n_pts, base_q);
        fill_d  = '0;
        past_d  = 1'b0;
      end

      if (have_e2) begin
        e2.run_last = 1'b1;
        e2.path_end = in_i.in_last;
      end else begin
        e1.run_last = 1'b1;
        e1.path_end = in_i.in_last;
      end
      pend_d[0]  = st_op;
      pend_d[1]  = e1;
      pend_d[2]  = e2;
      pend_cnt_d = 2'd1 + 2'(have_e1) + 2'(have_e2);
      pend_idx_d = 2'd0;
    end

    // A register write drops the path in progress.
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WINDOW_LENGTH: begin
          win_d  = cfg_data_i;
          fill_d = '0;
          past_d = 1'b0;
        end
        REG_OVERLAP_HALF: begin
          ovl_d  = cfg_data_i[OVL_W-1:0];
          fill_d = '0;
          past_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= WIN_RESET;
      ovl_q      <= OVL_RESET;
      fill_q     <= '0;
      base_q     <= '0;
      past_q     <= 1'b0;
      pend_cnt_q <= 2'd0;
      pend_idx_q <= 2'd0;
    end else begin
      win_q      <= win_d;
      ovl_q      <= ovl_d;
      fill_q     <= fill_d;
      base_q     <= base_d;
      past_q     <= past_d;
      pend_cnt_q <= pend_cnt_d;
      pend_idx_q <= pend_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

`default_nettype wire

// ----- design/wbps_div.sv -----
`default_nettype none

module wbps_div import wbps_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [NUM_W-1:0]  num_i,
  input  wire logic [CNT_W-1:0]         den_i,
  output logic                          done_o,
  output logic signed [COORD_W-1:0]     quot_o
);

  logic [NUM_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     den_q, den_d;
  logic                 neg_q, neg_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [CNT_W:0]       trial;
  logic [NUM_W-1:0]     q_up;

  assign trial  = {rem_q, quo_q[NUM_W-1]};
  assign q_up   = quo_q + NUM_W'(rem_q != '0);
  // Floor division: a negative dividend rounds its magnitude quotient up.
  assign quot_o = neg_q ? COORD_W'(-q_up) : COORD_W'(quo_q);
  assign done_o = done_q;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      neg_d  = num_i[NUM_W-1];
      quo_d  = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = CNT_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[CNT_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

endmodule

`default_nettype wire

// ----- design/wbps_back.sv -----
`default_nettype none

module wbps_back import wbps_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire op_t  op_i,
  input  wire logic op_valid_i,
  output logic      op_pop_o,
  output out_t      out_o,
  output logic      out_valid_o,
  input  wire logic out_pop_i
);

  back_state_e state_q, state_d;

  logic [2*COORD_W-1:0] pt_mem [MAX_WINDOW];
  logic [2*COORD_W-1:0] wk_mem [MAX_WINDOW];
  logic [2*COORD_W-1:0] pt0_q, pt1_q, wk0_q, wk1_q;

  op_t              job_q;
  logic [CNT_W-1:0] i_q;
  logic [PTR_W-1:0] r_q, j_q;
  logic [CNT_W-1:0] dgr;
  logic             first_round, more_j, more_i, out_free;

  logic signed [COORD_W-1:0] ax_q, ay_q, bx, by, res_x, res_y, qx, qy;
  logic signed [COORD_W-1:0] rx_q, ry_q;
  logic signed [COORD_W:0]   dx, dy;
  logic signed [CNT_W:0]     i_s;
  logic signed [NUM_W-1:0]   prodx, prody, prodx_q, prody_q, numx, numy;
  logic                      donex, doney;

  out_t out_q;
  logic out_valid_q;

  logic pt_we, wk_we, load_job, ld_prod, div_start, step_j, step_r, step_i, ld_out;

  assign dgr         = job_q.n - 1'b1;
  assign first_round = (r_q == dgr[PTR_W-1:0]);
  assign more_j      = ({1'b0, j_q} + 1'b1) < {1'b0, r_q};
  assign more_i      = (i_q + 1'b1) < job_q.stop;
  assign out_free    = ~out_valid_q | out_pop_i;

  // Lerp as a + floor((2*i*(b-a) + d) / (2*d)).
  logic [2*COORD_W-1:0] src0, src1;
  assign src0  = first_round ? pt0_q : wk0_q;
  assign src1  = first_round ? pt1_q : wk1_q;
  assign bx    = src1[2*COORD_W-1:COORD_W];
  assign by    = src1[COORD_W-1:0];
  assign dx    = (COORD_W+1)'(bx) - (COORD_W+1)'($signed(src0[2*COORD_W-1:COORD_W]));
  assign dy    = (COORD_W+1)'(by) - (COORD_W+1)'($signed(src0[COORD_W-1:0]));
  assign i_s   = {1'b0, i_q};
  assign prodx = NUM_W'(i_s) * NUM_W'(dx);
  assign prody = NUM_W'(i_s) * NUM_W'(dy);
  assign numx  = {prodx_q[NUM_W-2:0], 1'b0} + NUM_W'(dgr);
  assign numy  = {prody_q[NUM_W-2:0], 1'b0} + NUM_W'(dgr);
  assign res_x = ax_q + qx;
  assign res_y = ay_q + qy;

  wbps_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (numx),
    .den_i   ({dgr[CNT_W-2:0], 1'b0}),
    .done_o  (donex),
    .quot_o  (qx)
  );

  wbps_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (numy),
    .den_i   ({dgr[CNT_W-2:0], 1'b0}),
    .done_o  (doney),
    .quot_o  (qy)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (op_valid_i && op_i.kind == OP_EMIT) begin
          state_d = B_READ;
        end
      end
      B_READ: state_d = B_MUL;
      B_MUL:  state_d = B_PREP;
      B_PREP: state_d = B_DIV;
      B_DIV: begin
        if (donex && doney) begin
          if (more_j || r_q > PTR_W'(1)) begin
            state_d = B_READ;
          end else begin
            state_d = B_OUT;
          end
        end
      end
      B_OUT: begin
        if (out_free) begin
          state_d = more_i ? B_READ : B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    op_pop_o  = 1'b0;
    pt_we     = 1'b0;
    wk_we     = 1'b0;
    load_job  = 1'b0;
    ld_prod   = 1'b0;
    div_start = 1'b0;
    step_j    = 1'b0;
    step_r    = 1'b0;
    step_i    = 1'b0;
    ld_out    = 1'b0;
    case (state_q)
      B_IDLE: begin
        op_pop_o = op_valid_i;
        pt_we    = op_valid_i && op_i.kind == OP_STORE;
        load_job = op_valid_i && op_i.kind == OP_EMIT;
      end
      B_MUL:  ld_prod = 1'b1;
      B_PREP: div_start = 1'b1;
      B_DIV: begin
        if (donex && doney) begin
          wk_we  = 1'b1;
          step_j = more_j;
          step_r = ~more_j && r_q > PTR_W'(1);
        end
      end
      B_OUT: begin
        if (out_free) begin
          ld_out = 1'b1;
          step_i = more_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      r_q         <= '0;
      j_q         <= '0;
    end else begin
      state_q <= state_d;
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_job) begin
        i_q <= op_i.first;
        r_q <= PTR_W'(op_i.n - 1'b1);
        j_q <= '0;
      end else if (step_j) begin
        j_q <= j_q + 1'b1;
      end else if (step_r) begin
        r_q <= r_q - 1'b1;
        j_q <= '0;
      end else if (step_i) begin
        i_q <= i_q + 1'b1;
        r_q <= dgr[PTR_W-1:0];
        j_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_job) begin
      job_q <= op_i;
    end
    if (ld_prod) begin
      ax_q    <= $signed(src0[2*COORD_W-1:COORD_W]);
      ay_q    <= $signed(src0[COORD_W-1:0]);
      prodx_q <= prodx;
      prody_q <= prody;
    end
    if (wk_we) begin
      rx_q <= res_x;
      ry_q <= res_y;
    end
    if (ld_out) begin
      out_q.out_x    <= rx_q;
      out_q.out_y    <= ry_q;
      out_q.run_last <= job_q.run_last & ~more_i;
      out_q.path_end <= job_q.path_end & ~more_i;
    end
  end

  // Point store and work store, read data registered.
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[op_i.addr] <= {op_i.px, op_i.py};
    end
    pt0_q <= pt_mem[job_q.base + j_q];
    pt1_q <= pt_mem[job_q.base + j_q + 1'b1];
  end

  always_ff @(posedge clk_i) begin
    if (wk_we) begin
      wk_mem[j_q] <= {res_x, res_y};
    end
    wk0_q <= wk_mem[j_q];
    wk1_q <= wk_mem[j_q + 1'b1];
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- design/windowed_bezier_path_smoother.sv -----
// Windowed Bezier path smoother.
// Points enter as beats on push/full, one per path point, with in_last set on
// the final point of a path. Smoothed points leave through empty/pop: the
// oldest result sits on out_o while empty is low and leaves when pop is high.
// Window length and overlap half are written on cfg_we_i/cfg_idx_i/cfg_data_i
// while the block is idle, a rule on the user that the block does not enforce;
// a write drops the path in progress. After a point is taken the front passes
// its commands (one store and up to two curve jobs) into the command queue one
// at a time while the queue has room, and full stays high until all are taken.
// The back evaluates each sample by de Casteljau, one lerp pair at a time on
// two shared restoring dividers, with n*(n-1)/2 lerps per sample of an n-point
// curve. Results wait in one output register; while pop is low the back holds
// its next sample and the command queue fills, after which full stays high.
// Reset restores the default registers and empties both queues.
`default_nettype none

module windowed_bezier_path_smoother import wbps_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire in_t                   in_i,
  output logic                       empty,
  input  wire logic                  pop,
  output out_t                       out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  op_t  f_op, q_op;
  logic f_valid, f_ready, q_valid, q_pop, out_valid;

  wbps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .op_o       (f_op),
    .op_valid_o (f_valid),
    .op_ready_i (f_ready)
  );

  wbps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_op),
    .ready_o (f_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_op)
  );

  wbps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (q_op),
    .op_valid_i  (q_valid),
    .op_pop_o    (q_pop),
    .out_o       (out_o),
    .out_valid_o (out_valid),
    .out_pop_i   (pop & out_valid)
  );

  assign empty = ~out_valid;

endmodule

`default_nettype wire

// ----- test/windowed_bezier_path_smoother_test.sv -----
`timescale 1ns / 1ps

module windowed_bezier_path_smoother_test;
  import wbps_pkg::*;

  localparam int WATCHDOG_LIMIT = 150000;
  localparam int SETTLE_CYCLES  = 200;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  in_t                   in_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_t                  out_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  windowed_bezier_path_smoother uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_i(in_i),
    .empty(empty), .pop(pop), .out_o(out_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the smoother: control points, scratch row and path progress.
  longint    ctrl_x [MAX_WINDOW];
  longint    ctrl_y [MAX_WINDOW];
  longint    scr_x [MAX_WINDOW];
  longint    scr_y [MAX_WINDOW];
  int        held_pts;
  bit        in_later_window;
  int        win_reg;
  int        ovl_reg;
  out_t      smoothed_q [$];
  int        err_count = 0;
  bit        calm = 1'b0;

  function automatic longint lerp_round(longint a, longint b, longint i, longint d);
    longint num;
    longint den;
    longint q;
    num = 2 * ((d - i) * a + i * b) + d;
    den = 2 * d;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  task automatic sample_curve(input int n, input int first, input int stop, inout int k);
    out_t r;
    longint d;
    d = n - 1;
    for (int i = first; i < stop && k < MAX_WINDOW; i++) begin
      for (int j = 0; j < n; j++) begin
        scr_x[j] = ctrl_x[j];
        scr_y[j] = ctrl_y[j];
      end
      for (int lvl = n - 1; lvl > 0; lvl--) begin
        for (int j = 0; j < lvl; j++) begin
          scr_x[j] = lerp_round(scr_x[j], scr_x[j+1], i, d);
          scr_y[j] = lerp_round(scr_y[j], scr_y[j+1], i, d);
        end
      end
      r = '0;
      r.out_x = scr_x[0][COORD_W-1:0];
      r.out_y = scr_y[0][COORD_W-1:0];
      smoothed_q = {smoothed_q, r};
      k++;
    end
  endtask

  task automatic slide_window(input int len, input int keep);
    for (int j = 0; j < keep; j++) begin
      ctrl_x[j] = ctrl_x[len - keep + j];
      ctrl_y[j] = ctrl_y[len - keep + j];
    end
    held_pts = keep;
  endtask

  task automatic predict_point(input in_t pt);
    int wl;
    int hh;
    int cc;
    int n;
    int k;
    wl = win_reg;
    if (wl < 2) wl = 2;
    if (wl > MAX_WINDOW) wl = MAX_WINDOW;
    hh = ovl_reg;
    if (hh > (wl - 1) / 2) hh = (wl - 1) / 2;
    cc = 2 * hh;
    k = 0;
    if (held_pts >= wl) held_pts = 0;
    ctrl_x[held_pts] = longint'(pt.in_x);
    ctrl_y[held_pts] = longint'(pt.in_y);
    held_pts++;
    n = held_pts;
    if (!in_later_window) begin
      if (pt.in_last) begin
        if (n >= 2) sample_curve(n, 0, n, k);
        held_pts = 0;
      end else if (n == wl) begin
        sample_curve(wl, 0, wl - hh, k);
        slide_window(wl, cc);
        in_later_window = 1'b1;
      end
    end else if (n == wl) begin
      sample_curve(wl, hh, wl - hh, k);
      slide_window(wl, cc);
      if (pt.in_last) begin
        if (cc >= 2) sample_curve(cc, hh, cc, k);
        held_pts = 0;
        in_later_window = 1'b0;
      end
    end else if (pt.in_last) begin
      if (n >= 2) sample_curve(n, hh, n, k);
      held_pts = 0;
      in_later_window = 1'b0;
    end
    if (k > 0) begin
      smoothed_q[$].run_last = 1'b1;
      smoothed_q[$].path_end = pt.in_last;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic idle_burst();
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input bit last);
    push <= 1'b1;
    in_i.in_x <= x;
    in_i.in_y <= y;
    in_i.in_last <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_point('{in_x: x, in_y: y, in_last: last});
    idle_burst();
  endtask

  // Let every expected beat drain, then give the back time to finish stores.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) win_reg = int'(data);
    else ovl_reg = int'(data[OVL_W-1:0]);
    held_pts = 0;
    in_later_window = 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: checking, random stalls and the watchdog.
  int stall_left = 0;
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (smoothed_q.size() == 0) begin
          report_mismatch("unexpected beat", out_o.out_x, '0);
        end else begin
          want = smoothed_q.pop_front();
          if (out_o.out_x !== want.out_x) report_mismatch("out_x", out_o.out_x, want.out_x);
          if (out_o.out_y !== want.out_y) report_mismatch("out_y", out_o.out_y, want.out_y);
          if (out_o.run_last !== want.run_last)
            report_mismatch("run_last", 32'(out_o.run_last), 32'(want.run_last));
          if (out_o.path_end !== want.path_end)
            report_mismatch("path_end", 32'(out_o.path_end), 32'(want.path_end));
        end
      end
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("windowed_bezier_path_smoother_test: errors");
        $finish;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  typedef struct {
    bit          is_cfg;
    reg_idx_e    idx;
    logic [5:0]  data;
    logic [31:0] x;
    logic [31:0] y;
    bit          last;
    bit          typed;
    logic [31:0] ex;
    logic [31:0] ey;
  } plan_row_t;

  localparam reg_idx_e WL = REG_WINDOW_LENGTH;
  localparam reg_idx_e OH = REG_OVERLAP_HALF;

  plan_row_t plan [25];

  initial begin
    int wl;
    int budget;
    int len;
    plan = '{
      // A single point is a short path and produces nothing.
      '{0, WL, 0, 32'h7fffffff, 32'h80000000, 1, 0, 0, 0},
      '{0, WL, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0},
      '{0, WL, 0, 32'h80000000, 32'h7fffffff, 1, 1, 32'h80000000, 32'h7fffffff},
      '{1, WL, 6'd0, 0, 0, 0, 0, 0, 0},
      '{1, OH, 6'h3f, 0, 0, 0, 0, 0, 0},
      '{0, WL, 0, 32'd1, 32'd2, 0, 0, 0, 0},
      '{0, WL, 0, 32'd3, 32'd4, 0, 1, 32'd3, 32'd4},
      // With no overlap a tail of one point is dropped.
      '{0, WL, 0, 32'd5, 32'd6, 1, 0, 0, 0},
      '{0, WL, 0, 32'd7, 32'd8, 0, 0, 0, 0},
      '{0, WL, 0, 32'd9, 32'd10, 1, 1, 32'd9, 32'd10},
      '{1, WL, 6'd5, 0, 0, 0, 0, 0, 0},
      '{1, OH, 6'd1, 0, 0, 0, 0, 0, 0},
      '{0, WL, 0, 32'h00010000, 32'hffff0000, 0, 0, 0, 0},
      '{0, WL, 0, 32'h00050000, 32'h00030000, 0, 0, 0, 0},
      '{0, WL, 0, 32'hfff80000, 32'h00020000, 0, 0, 0, 0},
      '{0, WL, 0, 32'h00000001, 32'h7fff0000, 0, 0, 0, 0},
      '{0, WL, 0, 32'h12345678, 32'h80001234, 0, 0, 0, 0},
      '{0, WL, 0, 32'hdeadbeef, 32'h00000000, 0, 0, 0, 0},
      '{0, WL, 0, 32'h00000000, 32'h0badcafe, 0, 0, 0, 0},
      // A full later window that ends the path is followed by its tail.
      '{0, WL, 0, 32'h00400000, 32'hffc00000, 1, 1, 32'h00400000, 32'hffc00000},
      '{1, WL, 6'h3f, 0, 0, 0, 0, 0, 0},
      '{0, WL, 0, 32'h80000000, 32'h80000000, 0, 0, 0, 0},
      '{0, WL, 0, 32'h7fffffff, 32'h00000000, 0, 0, 0, 0},
      '{0, WL, 0, 32'h00000000, 32'h7fffffff, 1, 1, 32'h00000000, 32'h7fffffff},
      '{1, WL, 6'd32, 0, 0, 0, 0, 0, 0}
    };
    win_reg = 32;
    ovl_reg = 8;
    held_pts = 0;
    in_later_window = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        drain();
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        send_point(plan[r].x, plan[r].y, plan[r].last);
        if (plan[r].typed) begin
          smoothed_q[$].out_x = plan[r].ex;
          smoothed_q[$].out_y = plan[r].ey;
        end
      end
    end

    // Random phases: mostly short windows, one wider, overlap from all codes.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph == 7) calm = 1'b1;
      write_reg(REG_WINDOW_LENGTH, (ph == 3) ? 6'd10 : 6'($urandom_range(0, 6)));
      write_reg(REG_OVERLAP_HALF, 6'($urandom_range(0, 63)));
      wl = (win_reg < 2) ? 2 : win_reg;
      budget = 60;
      while (budget > 0) begin
        len = $urandom_range(1, 3 * wl + 2);
        // A path still open when the budget runs out is dropped by the next write.
        for (int j = 0; j < len && budget > 0; j++) begin
          if ($urandom_range(0, 3) == 0)
            send_point(32'($signed($urandom_range(0, 2000)) - 1000) <<< 12,
                       32'($signed($urandom_range(0, 2000)) - 1000) <<< 12, j == len - 1);
          else
            send_point($urandom, $urandom, j == len - 1);
          budget--;
        end
      end
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("windowed_bezier_path_smoother_test: clean");
    end else begin
      $display("windowed_bezier_path_smoother_test: errors");
    end
    $finish;
  end

endmodule
